// ===== hdl/agor_pkg.sv =====
`default_nettype none

package agor_pkg;

   // signed milli-g sample and intermediate widths
   typedef logic signed [15:0] mg_type;
   typedef logic signed [31:0] prod_type;
   typedef logic signed [32:0] gain_sum_type;
   typedef logic signed [33:0] rot_sum_type;

   // configuration port
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 48;
   localparam int unsigned FracBits      = 12;

   localparam logic [CsrIndexWidth-1:0] CSR_STAGE_ENABLES = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_AXIS_GAINS    = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_AXIS_OFFSETS  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_ROT_ROW_ZERO  = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_ROT_ROW_ONE   = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_ROT_ROW_TWO   = 3'd5;

   // register reset values
   localparam logic [1:0]              RST_STAGE_ENABLES = 2'b00;
   localparam logic [CsrDataWidth-1:0] RST_AXIS_GAINS    = 48'h1000_1000_1000;
   localparam logic [CsrDataWidth-1:0] RST_AXIS_OFFSETS  = 48'h0000_0000_0000;
   localparam logic [CsrDataWidth-1:0] RST_ROT_ROW_ZERO  = 48'h0000_0000_1000;
   localparam logic [CsrDataWidth-1:0] RST_ROT_ROW_ONE   = 48'h0000_1000_0000;
   localparam logic [CsrDataWidth-1:0] RST_ROT_ROW_TWO   = 48'h1000_0000_0000;

   // q.12 value to nearest integer, ties to even, saturated to 16 bits
   function automatic mg_type round_sat(input rot_sum_type acc);
      logic signed [21:0] quo;
      logic [11:0]        rem;
      logic               inc;
      logic signed [22:0] res;
      quo = acc[33:12];
      rem = acc[11:0];
      inc = (rem > 12'h800) || ((rem == 12'h800) && quo[0]);
      res = $signed({quo[21], quo}) + $signed({22'd0, inc});
      if (res > 23'sd32767) begin
         return 16'sh7fff;
      end else if (res < -23'sd32768) begin
         return 16'sh8000;
      end else begin
         return res[15:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== hdl/agor_sample_if.sv =====
`default_nettype none

interface agor_sample_if import agor_pkg::*; ();
   logic   valid;
   logic   ready;
   mg_type raw_x;
   mg_type raw_y;
   mg_type raw_z;

   modport source (output valid, output raw_x, output raw_y, output raw_z, input ready);
   modport sink (input valid, input raw_x, input raw_y, input raw_z, output ready);
endinterface

`default_nettype wire

// ===== hdl/agor_result_if.sv =====
`default_nettype none

interface agor_result_if import agor_pkg::*; ();
   logic   valid;
   logic   ready;
   mg_type out_x;
   mg_type out_y;
   mg_type out_z;

   modport source (output valid, output out_x, output out_y, output out_z, input ready);
   modport sink (input valid, input out_x, input out_y, input out_z, output ready);
endinterface

`default_nettype wire

// ===== hdl/accel_gain_offset_rotate_unit.sv =====
`default_nettype none
// accelerometer gain/offset correction and installation rotation
// req_chan carries one three-axis sample (raw_x/y/z, signed milli-g) per
// transaction; rsp_chan returns one corrected sample (out_x/y/z) for each.
// csr_wr_en/csr_index/csr_wdata write one of the six setup registers per write;
// write them only while no transaction is in flight.
// the datapath is a six-stage pipeline: gain multiply, offset add, round,
// nine rotation multiplies, row sums, round. a sample passes through the stages
// in that order to rsp_chan; one sample per cycle is sustained while rsp_chan.ready is high.
// each stage has its own valid bit and holds only when the stage after it
// is full and stalled, so req_chan keeps accepting into empty stages while
// a finished result waits on rsp_chan. with the receiver stalled the
// pipeline fills and req_chan.ready drops; nothing is lost or repeated.
// a disabled correction stage passes its sample through unchanged.
// synchronous reset empties the pipeline and loads unity gains, zero
// offsets, an identity matrix and both correction stages disabled.
module accel_gain_offset_rotate_unit
   import agor_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   agor_sample_if.sink                   req_chan,
   agor_result_if.source                 rsp_chan,
   input  wire logic                     csr_wr_en,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata
);

   localparam int unsigned NumStages = 6;

   // setup registers
   logic [1:0]              stage_en_ff;
   logic [CsrDataWidth-1:0] gains_ff;
   logic [CsrDataWidth-1:0] offsets_ff;
   logic [CsrDataWidth-1:0] rows_ff [3];

   // pipeline control
   logic [NumStages:1]   vld_ff;
   logic [NumStages:1]   vld_in;
   logic [NumStages+1:1] adv;
   logic                 in_fire;
   logic                 out_fire;

   // pipeline payload
   mg_type       raw_in   [3];
   prod_type     prod1_ff [3];
   mg_type       raw1_ff  [3];
   mg_type       off1_ff  [3];
   gain_sum_type sum2_ff  [3];
   mg_type       raw2_ff  [3];
   mg_type       v3_ff    [3];
   prod_type     prod4_ff [3][3];
   mg_type       v4_ff    [3];
   rot_sum_type  sum5_ff  [3];
   mg_type       v5_ff    [3];
   mg_type       out_ff   [3];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_en_ff <= RST_STAGE_ENABLES;
         gains_ff    <= RST_AXIS_GAINS;
         offsets_ff  <= RST_AXIS_OFFSETS;
         rows_ff[0]  <= RST_ROT_ROW_ZERO;
         rows_ff[1]  <= RST_ROT_ROW_ONE;
         rows_ff[2]  <= RST_ROT_ROW_TWO;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STAGE_ENABLES: stage_en_ff <= csr_wdata[1:0];
            CSR_AXIS_GAINS:    gains_ff    <= csr_wdata;
            CSR_AXIS_OFFSETS:  offsets_ff  <= csr_wdata;
            CSR_ROT_ROW_ZERO:  rows_ff[0]  <= csr_wdata;
            CSR_ROT_ROW_ONE:   rows_ff[1]  <= csr_wdata;
            CSR_ROT_ROW_TWO:   rows_ff[2]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // per-stage advance: a stage takes new data when empty or draining
   always_comb begin
      adv[NumStages+1] = rsp_chan.ready;
      for (int i = NumStages; i >= 1; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
      vld_in = vld_ff;
      if (adv[1]) begin
         vld_in[1] = req_chan.valid;
      end
      for (int i = 2; i <= NumStages; i++) begin
         if (adv[i]) begin
            vld_in[i] = vld_ff[i-1];
         end
      end
   end

   assign in_fire  = req_chan.valid && adv[1];
   assign out_fire = vld_ff[NumStages] && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      raw_in[0] = req_chan.raw_x;
      raw_in[1] = req_chan.raw_y;
      raw_in[2] = req_chan.raw_z;
   end

   // datapath stages
   always_ff @(posedge clock) begin
      // gain multiply
      if (adv[1]) begin
         for (int k = 0; k < 3; k++) begin
            prod1_ff[k] <= $signed(gains_ff[16*k +: 16]) * raw_in[k];
            raw1_ff[k]  <= raw_in[k];
            off1_ff[k]  <= offsets_ff[16*k +: 16];
         end
      end
      // offset add in q.12
      if (adv[2]) begin
         for (int k = 0; k < 3; k++) begin
            sum2_ff[k] <= $signed({prod1_ff[k][31], prod1_ff[k]})
                        + $signed({{5{off1_ff[k][15]}}, off1_ff[k], 12'h000});
            raw2_ff[k] <= raw1_ff[k];
         end
      end
      // round or bypass gain stage
      if (adv[3]) begin
         for (int k = 0; k < 3; k++) begin
            v3_ff[k] <= stage_en_ff[0] ? round_sat({sum2_ff[k][32], sum2_ff[k]})
                                       : raw2_ff[k];
         end
      end
      // rotation multiplies
      if (adv[4]) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod4_ff[r][c] <= $signed(rows_ff[r][16*c +: 16]) * v3_ff[c];
            end
         end
         for (int k = 0; k < 3; k++) begin
            v4_ff[k] <= v3_ff[k];
         end
      end
      // row sums
      if (adv[5]) begin
         for (int r = 0; r < 3; r++) begin
            sum5_ff[r] <= $signed({{2{prod4_ff[r][0][31]}}, prod4_ff[r][0]})
                        + $signed({{2{prod4_ff[r][1][31]}}, prod4_ff[r][1]})
                        + $signed({{2{prod4_ff[r][2][31]}}, prod4_ff[r][2]});
            v5_ff[r]   <= v4_ff[r];
         end
      end
      // round or bypass rotation, output register
      if (adv[6]) begin
         for (int k = 0; k < 3; k++) begin
            out_ff[k] <= stage_en_ff[1] ? round_sat(sum5_ff[k]) : v5_ff[k];
         end
      end
   end

   // channel outputs
   assign req_chan.ready = adv[1];
   assign rsp_chan.valid = vld_ff[NumStages];
   assign rsp_chan.out_x = out_ff[0];
   assign rsp_chan.out_y = out_ff[1];
   assign rsp_chan.out_z = out_ff[2];

`ifndef SYNTHESIS
   // items in flight change only by accepted and delivered transactions
   a_item_count: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(vld_ff) == $past($countones(vld_ff))
                + int'($past(in_fire)) - int'($past(out_fire))))
      else $error("pipeline occupancy does not match transactions");

   // a row sum that cannot move on is held
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[5] && !adv[6]) |=> (vld_ff[5] && $stable(sum5_ff[0])
                                  && $stable(sum5_ff[1]) && $stable(sum5_ff[2])))
      else $error("stalled row sum lost or changed");

   // an empty pipeline always takes a transaction
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      (vld_ff == '0) |-> req_chan.ready)
      else $error("empty pipeline refuses input");
`endif

endmodule

`default_nettype wire
